// ===== rtl/blr_pkg.sv =====
// shared types and constants of the line rasterizer
package blr_pkg;

  localparam int COORD_W    = 6;
  localparam int COLOR_W    = 8;
  localparam int IMAGE_SIZE = 64;
  localparam int ERR_W      = COORD_W + 4;

  // largest legal coordinate; anything above it saturates
  localparam logic [COORD_W-1:0] MAX_COORD =
    (IMAGE_SIZE - 1 > (1 << COORD_W) - 1) ? COORD_W'((1 << COORD_W) - 1)
                                          : COORD_W'(IMAGE_SIZE - 1);

  // condition on the error term that takes the diagonal step
  typedef enum logic [2:0] {
    TIE_NEVER = 3'd0,
    TIE_LT    = 3'd1,
    TIE_GT    = 3'd2,
    TIE_GE    = 3'd3,
    TIE_LE    = 3'd4
  } blr_tie_t;

  // per-line stepping setup
  typedef struct packed {
    logic                     x_major;
    logic                     x_dec;
    logic                     y_dec;
    blr_tie_t                 tie;
    logic signed [ERR_W-1:0]  err_init;
    logic signed [ERR_W-1:0]  inc;
    logic signed [ERR_W-1:0]  corr;
    logic [COORD_W-1:0]       steps;
  } blr_line_t;

endpackage

// ===== rtl/blr_octant.sv =====
// octant decode: directions, major axis, error terms and tie rule of one line
module blr_octant
  import blr_pkg::*;
(
  input  logic [COORD_W-1:0] x0,
  input  logic [COORD_W-1:0] y0,
  input  logic [COORD_W-1:0] x1,
  input  logic [COORD_W-1:0] y1,
  output blr_line_t          line
);

  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W:0]          adx_w;
  logic [COORD_W:0]          ady_w;
  logic [COORD_W-1:0]        adx;
  logic [COORD_W-1:0]        ady;
  logic signed [ERR_W-1:0]   dx_e;
  logic signed [ERR_W-1:0]   dy_e;
  logic signed [ERR_W-1:0]   minor2;
  logic                      dx_zero;
  logic                      dy_zero;
  logic                      x_major;
  logic                      same_sign;

  // signed deltas and magnitudes
  assign dx      = $signed({1'b0, x1}) - $signed({1'b0, x0});
  assign dy      = $signed({1'b0, y1}) - $signed({1'b0, y0});
  assign adx_w   = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
  assign ady_w   = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
  assign adx     = adx_w[COORD_W-1:0];
  assign ady     = ady_w[COORD_W-1:0];
  assign dx_e    = {{(ERR_W-COORD_W-1){dx[COORD_W]}}, dx};
  assign dy_e    = {{(ERR_W-COORD_W-1){dy[COORD_W]}}, dy};
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);

  // major axis: the longer delta, x on a tie of nonzero deltas
  assign x_major   = (!dx_zero && !dy_zero) ? (adx >= ady) : !dx_zero;
  assign same_sign = (dx[COORD_W] == dy[COORD_W]);
  assign minor2    = x_major ? (dy_e + dy_e) : (dx_e + dx_e);

  always_comb begin
    line.x_major  = x_major;
    line.x_dec    = dx[COORD_W];
    line.y_dec    = dy[COORD_W];
    line.err_init = x_major ? dx_e : dy_e;
    line.corr     = x_major ? (dx_e + dx_e) : (dy_e + dy_e);
    line.inc      = same_sign ? (ERR_W'(0) - minor2) : minor2;
    line.steps    = x_major ? adx : ady;
    // tie rule per octant
    if (dx_zero || dy_zero) begin
      line.tie = TIE_NEVER;
    end else begin
      case ({dx[COORD_W], dy[COORD_W]})
        2'b00:   line.tie = TIE_LT;
        2'b01:   line.tie = x_major ? TIE_LT : TIE_GT;
        2'b10:   line.tie = x_major ? TIE_GE : TIE_LE;
        2'b11:   line.tie = TIE_GE;
        default: line.tie = TIE_NEVER;
      endcase
    end
  end

endmodule

// ===== rtl/blr_err_step.sv =====
// error unit: one bresenham step of the doubled error term
module blr_err_step
  import blr_pkg::*;
(
  input  logic signed [ERR_W-1:0] err_in,
  input  logic signed [ERR_W-1:0] inc,
  input  logic signed [ERR_W-1:0] corr,
  input  blr_tie_t                tie,
  output logic signed [ERR_W-1:0] err_out,
  output logic                    diag
);

  logic signed [ERR_W-1:0] err_inc;
  logic                    neg;
  logic                    zero;

  // advance along the major axis
  assign err_inc = err_in + inc;
  assign neg     = err_inc[ERR_W-1];
  assign zero    = (err_inc == '0);

  // octant tie rule
  always_comb begin
    case (tie)
      TIE_LT:    diag = neg;
      TIE_GT:    diag = !neg && !zero;
      TIE_GE:    diag = !neg;
      TIE_LE:    diag = neg || zero;
      TIE_NEVER: diag = 1'b0;
      default:   diag = 1'b0;
    endcase
  end

  // correction on a diagonal step
  assign err_out = diag ? (err_inc + corr) : err_inc;

endmodule

// ===== rtl/bresenham_line_rasterizer_top.sv =====
// line rasterizer top: request capture, step sequencer and pixel output
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  x/y start and end, rgb color
//   out      output     out_valid/out_stall pixel x/y, rgb, last flag
//
// a line is accepted in idle, set up in setup, then stepped at one pixel per cycle
// while out is not stalled: max(|dx|,|dy|) + 1 pixels per request;
// the shared error unit sets the pace.
// in_stall is high from acceptance until the end point has been taken.
// a stall on out holds the current pixel and freezes the stepping.
// rst_n is synchronous, active low, and returns the block to idle.
module bresenham_line_rasterizer_top
  import blr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_x_start,
  input  logic [COORD_W-1:0] in_y_start,
  input  logic [COORD_W-1:0] in_x_end,
  input  logic [COORD_W-1:0] in_y_end,
  input  logic [COLOR_W-1:0] in_color_red,
  input  logic [COLOR_W-1:0] in_color_green,
  input  logic [COLOR_W-1:0] in_color_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COORD_W-1:0] out_pixel_x,
  output logic [COORD_W-1:0] out_pixel_y,
  output logic [COLOR_W-1:0] out_pixel_red,
  output logic [COLOR_W-1:0] out_pixel_green,
  output logic [COLOR_W-1:0] out_pixel_blue,
  output logic               out_last_pixel
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_LAST  = 4'b1000
  } blr_state_t;

  blr_state_t              state_r, state_nxt;
  logic [COORD_W-1:0]      x_r, x_nxt;
  logic [COORD_W-1:0]      y_r, y_nxt;
  logic [COORD_W-1:0]      x_end_r, y_end_r;
  logic [COLOR_W-1:0]      red_r, green_r, blue_r;
  blr_line_t               line_r, line_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [COORD_W-1:0]      cnt_r, cnt_nxt;
  blr_line_t               line_dec;
  logic signed [ERR_W-1:0] err_step;
  logic                    diag;
  logic                    in_acc;
  logic                    out_acc;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    clamp_coord = (v > MAX_COORD) ? MAX_COORD : v;
  endfunction

  // line setup from the captured end points
  blr_octant u_octant (
    .x0   (x_r),
    .y0   (y_r),
    .x1   (x_end_r),
    .y1   (y_end_r),
    .line (line_dec)
  );

  // shared error update
  blr_err_step u_err (
    .err_in  (err_r),
    .inc     (line_r.inc),
    .corr    (line_r.corr),
    .tie     (line_r.tie),
    .err_out (err_step),
    .diag    (diag)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RUN) || (state_r == ST_LAST);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    line_nxt  = line_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt     = clamp_coord(in_x_start);
          y_nxt     = clamp_coord(in_y_start);
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        line_nxt  = line_dec;
        err_nxt   = line_dec.err_init;
        cnt_nxt   = line_dec.steps;
        state_nxt = (line_dec.steps == '0) ? ST_LAST : ST_RUN;
      end
      ST_RUN: begin
        if (out_acc) begin
          if (cnt_r == COORD_W'(1)) begin
            // end point is always written as given
            x_nxt     = x_end_r;
            y_nxt     = y_end_r;
            state_nxt = ST_LAST;
          end else begin
            err_nxt = err_step;
            cnt_nxt = cnt_r - COORD_W'(1);
            if (line_r.x_major) begin
              x_nxt = line_r.x_dec ? x_r - COORD_W'(1) : x_r + COORD_W'(1);
              if (diag) begin
                y_nxt = line_r.y_dec ? y_r - COORD_W'(1) : y_r + COORD_W'(1);
              end
            end else begin
              y_nxt = line_r.y_dec ? y_r - COORD_W'(1) : y_r + COORD_W'(1);
              if (diag) begin
                x_nxt = line_r.x_dec ? x_r - COORD_W'(1) : x_r + COORD_W'(1);
              end
            end
          end
        end
      end
      ST_LAST: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    line_r <= line_nxt;
    err_r  <= err_nxt;
    cnt_r  <= cnt_nxt;
    if (in_acc) begin
      x_end_r <= clamp_coord(in_x_end);
      y_end_r <= clamp_coord(in_y_end);
      red_r   <= in_color_red;
      green_r <= in_color_green;
      blue_r  <= in_color_blue;
    end
  end

  // pixel output
  assign out_pixel_x     = x_r;
  assign out_pixel_y     = y_r;
  assign out_pixel_red   = red_r;
  assign out_pixel_green = green_r;
  assign out_pixel_blue  = blue_r;
  assign out_last_pixel  = (state_r == ST_LAST);

endmodule

// ===== rtl/blr_checker.sv =====
// port-level checks of the line rasterizer, bound to the top level
module blr_checker
  import blr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] out_pixel_x,
  input logic [COORD_W-1:0] out_pixel_y,
  input logic [COLOR_W-1:0] out_pixel_red,
  input logic               out_last_pixel
);

  // a stalled pixel holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y))
    else $error("stalled pixel changed");

  // requests are taken only while no pixel is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("request taken during a line");

  // the setup cycle follows every accepted request
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid && in_stall)
    else $error("no setup cycle after request");

  // a line continues with the same red component until its end point
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_pixel |=> out_valid && $stable(out_pixel_red))
    else $error("line ended early or color changed");

  // after the end point the block is idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_pixel |=> !out_valid && !in_stall)
    else $error("not idle after end point");

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_pixel_red  (out_pixel_red),
  .out_last_pixel (out_last_pixel)
);
